FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at a clock edge requires the consequent at the same edge.
`define MSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");

// Antecedent true at a clock edge requires the consequent at the next edge.
`define MSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

FILE: rtl/msc_pkg.sv
// Package for the multichannel sonar scanner: types, register map, constants.
// Used by the interfaces, the config block, the engine and the top level.
`default_nettype none

package msc_pkg;

    localparam int CHANNELS = 16;
    localparam int PADDR_W  = 5;

    typedef logic [3:0]  t_chan;
    typedef logic [2:0]  t_reg_idx;

    localparam t_reg_idx REG_ACTIVE_MASK   = 3'd0;
    localparam t_reg_idx REG_CHANNELS_USED = 3'd1;
    localparam t_reg_idx REG_MAX_MISSES    = 3'd2;
    localparam t_reg_idx REG_PING_SPACING  = 3'd3;
    localparam t_reg_idx REG_MAX_ECHO      = 3'd4;
    localparam t_reg_idx REG_RANGE_SCALE   = 3'd5;

    localparam logic [15:0] RST_ACTIVE_MASK   = 16'd255;
    localparam logic [4:0]  RST_CHANNELS_USED = 5'd8;
    localparam logic [7:0]  RST_MAX_MISSES    = 8'd1;
    localparam logic [23:0] RST_PING_SPACING  = 24'd50000;
    localparam logic [15:0] RST_MAX_ECHO      = 16'd23509;
    localparam logic [15:0] RST_RANGE_SCALE   = 16'd11151;

    localparam logic [7:0]  MISS_SAT  = 8'hFF;
    localparam logic [15:0] PULSE_SAT = 16'hFFFF;
    localparam logic [23:0] SINCE_SAT = 24'hFFFFFF;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RISE = 3'b010,
        PH_FALL = 3'b100
    } t_phase;

    typedef struct packed {
        logic [15:0] active_mask;
        logic [4:0]  channels_in_use;
        logic [7:0]  max_misses;
        logic [23:0] ping_spacing_ticks;
        logic [15:0] max_echo_ticks;
        logic [15:0] range_scale;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic        echo_level;
        t_chan       read_channel;
        logic [15:0] fallback_value;
    } t_item;

    typedef struct packed {
        logic [15:0] trigger_lines;
        t_chan       current_channel;
        logic        measurement_done;
        logic [15:0] read_range;
    } t_result;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic t_chan lowest_set(input logic [15:0] v);
        t_chan idx;
        idx = '0;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) begin
                idx = t_chan'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/msc_if.sv
// Valid/ready channel interfaces for scanner items and results.
// Depends on msc_pkg for the field types.
`default_nettype none

interface msc_in_if;
    logic          valid;
    logic          ready;
    logic          op;
    logic          echo_level;
    msc_pkg::t_chan read_channel;
    logic [15:0]   fallback_value;

    modport source (output valid, op, echo_level, read_channel, fallback_value,
                    input ready);
    modport sink   (input valid, op, echo_level, read_channel, fallback_value,
                    output ready);
endinterface

interface msc_out_if;
    logic          valid;
    logic          ready;
    logic [15:0]   trigger_lines;
    msc_pkg::t_chan current_channel;
    logic          measurement_done;
    logic [15:0]   read_range;

    modport source (output valid, trigger_lines, current_channel, measurement_done,
                    read_range, input ready);
    modport sink   (input valid, trigger_lines, current_channel, measurement_done,
                    read_range, output ready);
endinterface

`default_nettype wire

FILE: rtl/msc_cfg.sv
// APB-style configuration register file of the sonar scanner.
// Depends on msc_pkg for the register map and the t_cfg struct.
`default_nettype none

module msc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output msc_pkg::t_cfg                      o_cfg
);

    msc_pkg::t_cfg    r_cfg;
    msc_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_mask        <= msc_pkg::RST_ACTIVE_MASK;
            r_cfg.channels_in_use    <= msc_pkg::RST_CHANNELS_USED;
            r_cfg.max_misses         <= msc_pkg::RST_MAX_MISSES;
            r_cfg.ping_spacing_ticks <= msc_pkg::RST_PING_SPACING;
            r_cfg.max_echo_ticks     <= msc_pkg::RST_MAX_ECHO;
            r_cfg.range_scale        <= msc_pkg::RST_RANGE_SCALE;
        end else if (wr_en) begin
            unique case (reg_idx)
                msc_pkg::REG_ACTIVE_MASK:   r_cfg.active_mask        <= pwdata[15:0];
                msc_pkg::REG_CHANNELS_USED: r_cfg.channels_in_use    <= pwdata[4:0];
                msc_pkg::REG_MAX_MISSES:    r_cfg.max_misses         <= pwdata[7:0];
                msc_pkg::REG_PING_SPACING:  r_cfg.ping_spacing_ticks <= pwdata[23:0];
                msc_pkg::REG_MAX_ECHO:      r_cfg.max_echo_ticks     <= pwdata[15:0];
                msc_pkg::REG_RANGE_SCALE:   r_cfg.range_scale        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            msc_pkg::REG_ACTIVE_MASK:   prdata = {16'd0, r_cfg.active_mask};
            msc_pkg::REG_CHANNELS_USED: prdata = {27'd0, r_cfg.channels_in_use};
            msc_pkg::REG_MAX_MISSES:    prdata = {24'd0, r_cfg.max_misses};
            msc_pkg::REG_PING_SPACING:  prdata = {8'd0, r_cfg.ping_spacing_ticks};
            msc_pkg::REG_MAX_ECHO:      prdata = {16'd0, r_cfg.max_echo_ticks};
            msc_pkg::REG_RANGE_SCALE:   prdata = {16'd0, r_cfg.range_scale};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/msc_engine.sv
// Scanner engine: echo timing, ping scheduling, range and miss storage.
// Depends on msc_pkg; computes one item's result and commits state on i_go.
`default_nettype none

module msc_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire msc_pkg::t_cfg   i_cfg,
    input  wire msc_pkg::t_item  i_item,
    input  wire logic            i_go,
    output msc_pkg::t_result     o_res
);

    logic [15:0]      r_range [msc_pkg::CHANNELS];
    logic [7:0]       r_miss  [msc_pkg::CHANNELS];
    msc_pkg::t_phase  r_phase;
    msc_pkg::t_chan   r_cur;
    logic [23:0]      r_since;
    logic [15:0]      r_pulse;
    logic             r_prev;
    logic [15:0]      r_trig;

    logic [15:0]      n_range [msc_pkg::CHANNELS];
    logic [7:0]       n_miss  [msc_pkg::CHANNELS];
    msc_pkg::t_phase  n_phase;
    msc_pkg::t_chan   n_cur;
    logic [23:0]      n_since;
    logic [15:0]      n_pulse;
    logic             n_prev;
    logic [15:0]      n_trig;

    logic [23:0]      since_inc;
    logic [15:0]      pulse_inc;
    logic [7:0]       miss_inc;
    logic [31:0]      product;
    logic [4:0]       n_used;
    logic [16:0]      used_mask;
    logic [15:0]      cand;
    logic [15:0]      cand_hi;
    logic [4:0]       cur_plus;
    msc_pkg::t_chan   start;
    msc_pkg::t_chan   pick;
    logic             found;
    logic             echo;
    logic             miss_hit;
    logic             done;
    logic [15:0]      rd_range;
    logic [15:0]      stored;

    assign echo      = i_item.echo_level;
    assign since_inc = (r_since == msc_pkg::SINCE_SAT) ? r_since : r_since + 24'd1;
    assign pulse_inc = (r_pulse == msc_pkg::PULSE_SAT) ? r_pulse : r_pulse + 16'd1;
    assign miss_inc  = (r_miss[r_cur] == msc_pkg::MISS_SAT) ? r_miss[r_cur]
                                                             : r_miss[r_cur] + 8'd1;
    assign product   = {16'd0, pulse_inc} * {16'd0, i_cfg.range_scale};

    // Channel count clamped to one through CHANNELS.
    always_comb begin
        if (i_cfg.channels_in_use == 5'd0) begin
            n_used = 5'd1;
        end else if (i_cfg.channels_in_use > 5'(msc_pkg::CHANNELS)) begin
            n_used = 5'(msc_pkg::CHANNELS);
        end else begin
            n_used = i_cfg.channels_in_use;
        end
    end

    // Round-robin pick: first enabled channel from the one after the current,
    // wrapping at the channel count, with the current channel tried last.
    assign used_mask = (17'd1 << n_used) - 17'd1;
    assign cand      = i_cfg.active_mask & used_mask[15:0];
    assign cur_plus  = {1'b0, r_cur} + 5'd1;
    assign start     = (cur_plus >= n_used) ? '0 : cur_plus[3:0];
    assign cand_hi   = cand & ~((16'd1 << start) - 16'd1);
    assign found     = (cand != 16'd0);
    assign pick      = (cand_hi != 16'd0) ? msc_pkg::lowest_set(cand_hi)
                                          : msc_pkg::lowest_set(cand);

    assign stored = ({1'b0, i_item.read_channel} < 5'(msc_pkg::CHANNELS))
                    ? r_range[i_item.read_channel] : 16'd0;

    always_comb begin
        n_range  = r_range;
        n_miss   = r_miss;
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_since  = r_since;
        n_pulse  = r_pulse;
        n_prev   = r_prev;
        n_trig   = r_trig;
        miss_hit = 1'b0;
        done     = 1'b0;
        rd_range = 16'd0;
        if (i_item.op == msc_pkg::OP_READ) begin
            rd_range = (stored == 16'd0) ? i_item.fallback_value : stored;
        end else begin
            n_since = since_inc;
            unique case (r_phase)
                msc_pkg::PH_RISE: begin
                    if (echo && !r_prev) begin
                        n_pulse = '0;
                        n_phase = msc_pkg::PH_FALL;
                    end
                end
                msc_pkg::PH_FALL: begin
                    n_pulse = pulse_inc;
                    if (!echo) begin
                        if (pulse_inc > i_cfg.max_echo_ticks) begin
                            miss_hit = 1'b1;
                        end else begin
                            n_miss[r_cur]  = '0;
                            n_range[r_cur] = product[31:16];
                            done           = 1'b1;
                        end
                        n_phase = msc_pkg::PH_IDLE;
                    end
                end
                default: n_phase = msc_pkg::PH_IDLE;
            endcase

            if (since_inc > i_cfg.ping_spacing_ticks) begin
                // An echo still pending at ping time is a miss.
                if (n_phase != msc_pkg::PH_IDLE) begin
                    miss_hit = 1'b1;
                end
                n_phase = msc_pkg::PH_IDLE;
                n_trig  = '1;
                if (found) begin
                    n_since = '0;
                    n_cur   = pick;
                    n_trig  = ~(16'd1 << pick);
                    if (echo) begin
                        n_range[pick] = '0;
                    end else begin
                        n_phase = msc_pkg::PH_RISE;
                    end
                end
            end

            // At most one miss per tick, always on the channel pinged last.
            if (miss_hit) begin
                n_miss[r_cur] = miss_inc;
                if (miss_inc > i_cfg.max_misses) begin
                    n_range[r_cur] = '0;
                end
            end
            n_prev = echo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msc_pkg::CHANNELS; i++) begin
                r_range[i] <= '0;
                r_miss[i]  <= '0;
            end
            r_phase <= msc_pkg::PH_IDLE;
            r_cur   <= '0;
            r_since <= '0;
            r_pulse <= '0;
            r_prev  <= 1'b0;
            r_trig  <= '1;
        end else if (i_go) begin
            r_range <= n_range;
            r_miss  <= n_miss;
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_since <= n_since;
            r_pulse <= n_pulse;
            r_prev  <= n_prev;
            r_trig  <= n_trig;
        end
    end

    assign o_res.trigger_lines    = n_trig;
    assign o_res.current_channel  = n_cur;
    assign o_res.measurement_done = done;
    assign o_res.read_range       = rd_range;

endmodule

`default_nettype wire

FILE: rtl/multichannel_sonar_scanner_core.sv
// Multichannel sonar scanner top level: channel registers and handshakes.
// Depends on msc_pkg, msc_if, msc_cfg, msc_engine and assert_macros.svh.
//
// Usage: items arrive on i_in (valid/ready). A tick item stands for one
// microsecond and carries the shared echo sample; a read item asks for the
// stored range of one channel. Every item yields exactly one result on o_out,
// in order: the trigger lines, the channel pinged last, a done flag for a
// fresh measurement and, for reads, the range or the fallback value.
// Each item passes the input register and then the result register before
// o_out offers its result. Throughput is one item per cycle while o_out is
// not stalled; the path from the input register to the result register
// holds one 16x16 multiply and a 16-way priority pick. Registers must be
// written over the APB port while no item is in flight, which the block
// does not enforce. Reset clears all ranges and miss counts, releases all
// triggers and loads the register defaults. When o_out is stalled the
// result register holds, one more item is taken in, then i_in.ready drops.
`default_nettype none

`include "assert_macros.svh"

module multichannel_sonar_scanner_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    msc_in_if.sink                           i_in,
    msc_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [msc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    msc_pkg::t_cfg    cfg;
    msc_pkg::t_item   r_in_item;
    logic             r_in_valid;
    msc_pkg::t_result r_out;
    logic             r_out_valid;
    msc_pkg::t_result res;
    logic             advance;
    logic [15:0]      trig_active;
    logic             out_trig;

    msc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (r_in_item),
        .i_go    (advance && r_in_valid),
        .o_res   (res)
    );

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = advance || !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.op             <= i_in.op;
            r_in_item.echo_level     <= i_in.echo_level;
            r_in_item.read_channel   <= i_in.read_channel;
            r_in_item.fallback_value <= i_in.fallback_value;
        end
        if (advance && r_in_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.trigger_lines    = r_out.trigger_lines;
    assign o_out.current_channel  = r_out.current_channel;
    assign o_out.measurement_done = r_out.measurement_done;
    assign o_out.read_range       = r_out.read_range;

    assign trig_active = ~o_out.trigger_lines;
    assign out_trig    = o_out.valid && (trig_active != 16'd0);

    // At most one trigger is driven low at a time.
    `MSC_ASSERT_IMPLIES(a_one_trigger, i_clk, i_rst_n, o_out.valid, $onehot0(trig_active))
    // A low trigger always belongs to the channel reported as pinged.
    `MSC_ASSERT_IMPLIES(a_trig_chan, i_clk, i_rst_n, out_trig, trig_active[o_out.current_channel])
    // A taken result frees the output side, so input must be open.
    `MSC_ASSERT_IMPLIES(a_drain_ready, i_clk, i_rst_n, o_out.ready, i_in.ready)
    // An input transfer always lands in the input register.
    `MSC_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n, i_in.valid && i_in.ready, r_in_valid)

endmodule

`default_nettype wire
